// ===== hw/rtl/mouse_event_read_matcher_assert.svh =====
`ifndef MOUSE_EVENT_READ_MATCHER_ASSERT_SVH
`define MOUSE_EVENT_READ_MATCHER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define MEVRM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define MEVRM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mevrm_pkg.sv =====
package mevrm_pkg;

	localparam int EVENT_DEPTH = 32;
	localparam int TAG_DEPTH   = 16;
	localparam int EV_PTR_W    = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
	localparam int TAG_PTR_W   = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_X = 2'd0,
		CFG_MIN_Y = 2'd1,
		CFG_MAX_X = 2'd2,
		CFG_MAX_Y = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_MOUSE  = 2'd0,
		ACT_READ   = 2'd1,
		ACT_RESIZE = 2'd2
	} action_t;

	localparam logic STATUS_REPLY    = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;

	typedef logic [EV_PTR_W-1:0]  ev_ptr_t;
	typedef logic [TAG_PTR_W-1:0] tag_ptr_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [4:0]         button_bits;
		logic [31:0]        time_ms;
		logic [7:0]         req_tag;
	} in_item_t;

	typedef struct packed {
		logic               status;
		logic [7:0]         reply_tag;
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic [4:0]         out_buttons;
		logic [31:0]        out_time;
		logic               was_resized;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [4:0]         buttons;
		logic [31:0]        time_ms;
	} ev_entry_t;

	function automatic ev_ptr_t ev_next(input ev_ptr_t p);
		return (p == EV_PTR_W'(EVENT_DEPTH - 1)) ? '0 : ev_ptr_t'(p + 1'b1);
	endfunction

	function automatic tag_ptr_t tag_next(input tag_ptr_t p);
		return (p == TAG_PTR_W'(TAG_DEPTH - 1)) ? '0 : tag_ptr_t'(p + 1'b1);
	endfunction

endpackage

// ===== hw/rtl/mevrm_if.sv =====
interface mevrm_in_if;
	logic                valid;
	logic                ready;
	mevrm_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mevrm_out_if;
	logic                 valid;
	logic                 ready;
	mevrm_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mouse_event_read_matcher.sv =====
// channel     dir  handshake      payload
// item_ch     in   valid/ready    action, pos_x, pos_y, button_bits, time_ms, req_tag
// result_ch   out  valid/ready    status, reply_tag, out_x, out_y, out_buttons, out_time,
//                                 was_resized
// cfg         in   cfg_we only    cfg_idx, cfg_data
//
// One item per cycle sustained while result_ch is not stalled; not every item yields a result.
// The input register feeds the clamp, ring update and match logic into the result register.
// arst_n clears pointers, flags and valids; ring contents are undefined until written.
// A stalled result_ch holds the result register and then the input register.
module mouse_event_read_matcher (
	input  logic                                  clk,
	input  logic                                  arst_n,
	mevrm_in_if.sink                              item_ch,
	mevrm_out_if.source                           result_ch,
	input  logic                                  cfg_we,
	input  logic [mevrm_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [mevrm_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic signed [15:0] min_x_q, min_y_q, max_x_q, max_y_q;

	logic                 valid_s1;
	mevrm_pkg::in_item_t  item_s1;
	logic                 out_valid_q;
	mevrm_pkg::out_item_t out_item_q;
	logic                 advance;

	mevrm_pkg::ev_entry_t ev_mem_q [mevrm_pkg::EVENT_DEPTH];
	logic [7:0]           tag_mem_q [mevrm_pkg::TAG_DEPTH];

	mevrm_pkg::ev_ptr_t  ev_rd_q, ev_wr_q, ev_rd_n, ev_wr_n, ev_inc, ev_widx;
	mevrm_pkg::tag_ptr_t tag_rd_q, tag_wr_q, tag_rd_n, tag_wr_n, tag_inc;
	logic                stalled_q, stalled_n;
	logic                resize_q, resize_n;
	logic [4:0]          last_btn_q, last_btn_n;

	logic                 ev_we, tag_we, overflow, res_load;
	logic signed [15:0]   x_lo, y_lo, x_c, y_c;
	mevrm_pkg::ev_entry_t ev_new, ev_rd_data;
	logic [7:0]           tag_rd_data;
	mevrm_pkg::out_item_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= 16'sd0;
			min_y_q <= 16'sd0;
			max_x_q <= 16'sh7FFF;
			max_y_q <= 16'sh7FFF;
		end else if (cfg_we) begin
			unique case (mevrm_pkg::cfg_reg_t'(cfg_idx))
				mevrm_pkg::CFG_MIN_X: min_x_q <= cfg_data;
				mevrm_pkg::CFG_MIN_Y: min_y_q <= cfg_data;
				mevrm_pkg::CFG_MAX_X: max_x_q <= cfg_data;
				mevrm_pkg::CFG_MAX_Y: max_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance       = valid_s1 && (!out_valid_q || result_ch.ready);
	assign item_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ch.valid && item_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ch.valid && item_ch.ready) begin
			item_s1 <= item_ch.data;
		end
	end

	always_comb begin
		x_lo = (item_s1.pos_x < min_x_q) ? min_x_q : item_s1.pos_x;
		x_c  = (x_lo > max_x_q) ? max_x_q : x_lo;
		y_lo = (item_s1.pos_y < min_y_q) ? min_y_q : item_s1.pos_y;
		y_c  = (y_lo > max_y_q) ? max_y_q : y_lo;

		ev_new.x       = x_c;
		ev_new.y       = y_c;
		ev_new.buttons = item_s1.button_bits;
		ev_new.time_ms = item_s1.time_ms;

		ev_inc  = mevrm_pkg::ev_next(ev_wr_q);
		tag_inc = mevrm_pkg::tag_next(tag_wr_q);

		ev_rd_n    = ev_rd_q;
		ev_wr_n    = ev_wr_q;
		tag_rd_n   = tag_rd_q;
		tag_wr_n   = tag_wr_q;
		stalled_n  = stalled_q;
		resize_n   = resize_q;
		last_btn_n = last_btn_q;
		ev_we      = 1'b0;
		ev_widx    = ev_wr_q;
		tag_we     = 1'b0;
		overflow   = 1'b0;
		res_load   = 1'b0;
		res        = '0;

		unique case (mevrm_pkg::action_t'(item_s1.action))
			mevrm_pkg::ACT_MOUSE: begin
				if (!stalled_q && (ev_rd_q == ev_wr_q || last_btn_q != item_s1.button_bits)) begin
					last_btn_n = item_s1.button_bits;
					ev_we      = 1'b1;
					if (ev_inc == ev_rd_q) begin
						// ring full: restart with only the newest event
						stalled_n = 1'b1;
						ev_rd_n   = '0;
						ev_wr_n   = mevrm_pkg::EV_PTR_W'(1);
						ev_widx   = '0;
					end else begin
						ev_wr_n = ev_inc;
					end
				end
			end
			mevrm_pkg::ACT_READ: begin
				if (tag_inc == tag_rd_q) begin
					overflow = 1'b1;
				end else begin
					tag_we    = 1'b1;
					tag_wr_n  = tag_inc;
					stalled_n = 1'b0;
				end
			end
			mevrm_pkg::ACT_RESIZE: begin
				resize_n = 1'b1;
			end
			default: ;
		endcase

		ev_rd_data  = (ev_we && ev_widx == ev_rd_n) ? ev_new : ev_mem_q[ev_rd_n];
		tag_rd_data = (tag_we && tag_wr_q == tag_rd_n) ? item_s1.req_tag : tag_mem_q[tag_rd_n];

		if (overflow) begin
			res_load      = 1'b1;
			res.status    = mevrm_pkg::STATUS_OVERFLOW;
			res.reply_tag = item_s1.req_tag;
		end else if (ev_rd_n != ev_wr_n && tag_rd_n != tag_wr_n) begin
			res_load        = 1'b1;
			res.status      = mevrm_pkg::STATUS_REPLY;
			res.reply_tag   = tag_rd_data;
			res.out_x       = ev_rd_data.x;
			res.out_y       = ev_rd_data.y;
			res.out_buttons = ev_rd_data.buttons;
			res.out_time    = ev_rd_data.time_ms;
			res.was_resized = resize_n;
			resize_n        = 1'b0;
			ev_rd_n         = mevrm_pkg::ev_next(ev_rd_n);
			tag_rd_n        = mevrm_pkg::tag_next(tag_rd_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_rd_q    <= '0;
			ev_wr_q    <= '0;
			tag_rd_q   <= '0;
			tag_wr_q   <= '0;
			stalled_q  <= 1'b0;
			resize_q   <= 1'b0;
			last_btn_q <= '0;
		end else if (advance) begin
			ev_rd_q    <= ev_rd_n;
			ev_wr_q    <= ev_wr_n;
			tag_rd_q   <= tag_rd_n;
			tag_wr_q   <= tag_wr_n;
			stalled_q  <= stalled_n;
			resize_q   <= resize_n;
			last_btn_q <= last_btn_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ev_we) begin
			ev_mem_q[ev_widx] <= ev_new;
		end
		if (advance && tag_we) begin
			tag_mem_q[tag_wr_q] <= item_s1.req_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_load;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= res;
		end
	end

	assign result_ch.valid = out_valid_q;
	assign result_ch.data  = out_item_q;

`include "mouse_event_read_matcher_assert.svh"

	`MEVRM_ASSERT_NOW(a_one_ring_empty, 1'b1, ev_rd_q == ev_wr_q || tag_rd_q == tag_wr_q, "both rings hold entries after a match")
	`MEVRM_ASSERT_NOW(a_stall_has_event, stalled_q, ev_rd_q != ev_wr_q, "stalled with an empty event ring")
	`MEVRM_ASSERT_NOW(a_hold_blocks_input, valid_s1 && out_valid_q && !result_ch.ready, !item_ch.ready, "item taken while result is held")

endmodule
